@@ rtl/sliding_window_latency_stats_defines.svh @@
// assertion macros for the sliding window latency stats block
// used by the top level only; empty when SYNTHESIS is defined
`ifndef SLIDING_WINDOW_LATENCY_STATS_DEFINES_SVH
`define SLIDING_WINDOW_LATENCY_STATS_DEFINES_SVH

`ifndef SYNTHESIS
`define SWLS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWLS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWLS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWLS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/swls_pkg.sv @@
// shared constants and types for the sliding window latency stats block
// no dependencies
`default_nettype none

package swls_pkg;

	localparam int SAMPLE_W   = 20;
	localparam int PCT_W      = 7;
	localparam int WINDOW     = 64;
	localparam int AW         = $clog2(WINDOW);
	localparam int CW         = $clog2(WINDOW + 1);
	localparam int SW         = SAMPLE_W + AW;
	localparam int DVW        = (CW > PCT_W) ? CW : PCT_W;
	localparam int DW         = SW;
	localparam int DIVCW      = $clog2(DW + 1);
	localparam int NDIG       = SAMPLE_W / 2;
	localparam int DIGW       = $clog2(NDIG);
	localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((3 * SAMPLE_W + 7) / 8) * 8;

	// x / 100 as (x * PCT_RECIP) >> RECIP_SH, exact for x up to (WINDOW-1)*100
	localparam int PW         = CW + PCT_W;
	localparam int RECIP_SH   = 19;
	localparam int RECIP_W    = 13;
	localparam int RMW        = PW + RECIP_W;

	localparam logic [PCT_W-1:0]   PCT_RESET = 7'd95;
	localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
	localparam logic [RECIP_W-1:0] PCT_RECIP = 13'd5243;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANK_DIV,
		S_PASS,
		S_MEAN_DIV,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/sliding_window_latency_stats.sv @@
// sliding window latency stats: mean, percentile and max over the last samples
// depends on swls_pkg, swls_ram and sliding_window_latency_stats_defines.svh
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata[19:0] sample_us
//   m_*       out  m_tvalid/m_tready  m_tdata mean_us, percentile_us, max_us
//   cfg_*     in   cfg_we             cfg_wdata percentile
//
// a request runs ten radix-4 counting passes over the single read port of the ram, then the
// mean divide, before the next request is accepted
// the rank divide by 100 is a reciprocal multiply; the mean divide is a restoring
// divider, one quotient bit a cycle
// reset leaves the window ram as is; only positions below the fill count are ever read
// a result waits in the output register while the next request is taken
`default_nettype none
`include "sliding_window_latency_stats_defines.svh"

module sliding_window_latency_stats (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [swls_pkg::S_TDATA_W-1:0]  s_tdata,   // sample_us
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [swls_pkg::M_TDATA_W-1:0]  m_tdata,   // mean_us, percentile_us, max_us
	input  wire logic                            cfg_we,
	input  wire logic [swls_pkg::PCT_W-1:0]      cfg_wdata  // percentile
);

	import swls_pkg::*;

	state_t state_q, state_d;

	logic [PCT_W-1:0]    pct_q;
	logic [AW-1:0]       wpos_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       rd_idx_q;
	logic                issue_q;
	logic                vld_s1;
	logic [SAMPLE_W-1:0] rdata;
	logic [AW-1:0]       rank_q;
	logic [DIGW-1:0]     dig_q;
	logic [SAMPLE_W-1:0] ans_q;
	logic [SW-1:0]       sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [CW-1:0]       cnt_q [1:3];
	logic [DVW-1:0]      div_rem_q;
	logic [DW-1:0]       div_quo_q;
	logic [DVW-1:0]      div_den_q;
	logic [DIVCW-1:0]    div_cnt_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                in_acc;
	logic                pass_end;
	logic                div_done;
	logic                out_load;
	logic [CW-1:0]       count_nx;
	logic [CW-1:0]       cm1;
	logic [PCT_W-1:0]    pct_c;
	logic [CW+PCT_W-1:0] prod;
	logic [RMW-1:0]      rank_mul;
	logic [SAMPLE_W-1:0] cand [1:3];
	logic [1:0]          sel;
	logic [SAMPLE_W-1:0] ans_nx;
	logic [CW-1:0]       rank_c;
	logic [DVW:0]        rem_sh;
	logic                ge;
	logic [DVW-1:0]      rem_nx;

	swls_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW)
	) u_window (
		.clk  (clk),
		.we   (in_acc),
		.waddr(wpos_q),
		.wdata(s_tdata[SAMPLE_W-1:0]),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		in_acc   = s_tvalid && s_tready;
		pass_end = (state_q == S_PASS) && !issue_q && !vld_s1;
		div_done = (div_cnt_q == '0);
		out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
		count_nx = (count_q == CW'(WINDOW)) ? count_q : count_q + 1'b1;
		cm1      = count_nx - 1'b1;
		pct_c    = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
		prod     = (CW+PCT_W)'(cm1) * (CW+PCT_W)'(pct_c);
		rank_mul = RMW'(div_quo_q[PW-1:0]) * RMW'(PCT_RECIP);
		rank_c   = CW'(rank_q);
		for (int d = 1; d <= 3; d++) begin
			cand[d] = ans_q | (SAMPLE_W'(d) << {dig_q, 1'b0});
		end
		if (cnt_q[3] <= rank_c) begin
			sel = 2'd3;
		end else if (cnt_q[2] <= rank_c) begin
			sel = 2'd2;
		end else if (cnt_q[1] <= rank_c) begin
			sel = 2'd1;
		end else begin
			sel = 2'd0;
		end
		ans_nx = ans_q | (SAMPLE_W'(sel) << {dig_q, 1'b0});
		rem_sh = {div_rem_q, div_quo_q[DW-1]};
		ge     = (rem_sh >= {1'b0, div_den_q});
		rem_nx = ge ? DVW'(rem_sh - {1'b0, div_den_q}) : DVW'(rem_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_RANK_DIV;
			end
			S_RANK_DIV: begin
				state_d = S_PASS;
			end
			S_PASS: begin
				if (pass_end && dig_q == '0) state_d = S_MEAN_DIV;
			end
			S_MEAN_DIV: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q      <= PCT_RESET;
			wpos_q     <= '0;
			count_q    <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			rd_idx_q   <= '0;
			dig_q      <= '0;
		end else begin
			if (cfg_we) pct_q <= cfg_wdata;
			vld_s1 <= issue_q;
			if (in_acc) begin
				wpos_q    <= wpos_q + 1'b1;
				count_q   <= count_nx;
			end
			if (state_q == S_MEAN_DIV && !div_done) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (state_q == S_RANK_DIV) begin
				issue_q  <= 1'b1;
				rd_idx_q <= '0;
				dig_q    <= DIGW'(NDIG - 1);
			end
			if (issue_q) begin
				if (CW'(rd_idx_q) + 1'b1 == count_q) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (pass_end) begin
				if (dig_q == '0) begin
					div_cnt_q <= DIVCW'(DW);
				end else begin
					dig_q    <= dig_q - 1'b1;
					issue_q  <= 1'b1;
					rd_idx_q <= '0;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			div_quo_q <= DW'(prod);
		end
		if (state_q == S_MEAN_DIV && !div_done) begin
			div_rem_q <= rem_nx;
			div_quo_q <= {div_quo_q[DW-2:0], ge};
		end
		if (state_q == S_RANK_DIV) begin
			rank_q <= rank_mul[RECIP_SH +: AW];
			ans_q  <= '0;
			sum_q  <= '0;
			max_q  <= '0;
			for (int d = 1; d <= 3; d++) cnt_q[d] <= '0;
		end
		if (vld_s1) begin
			for (int d = 1; d <= 3; d++) begin
				if (rdata < cand[d]) cnt_q[d] <= cnt_q[d] + 1'b1;
			end
			if (dig_q == DIGW'(NDIG - 1)) begin
				sum_q <= sum_q + SW'(rdata);
				if (rdata > max_q) max_q <= rdata;
			end
		end
		if (pass_end) begin
			ans_q <= ans_nx;
			for (int d = 1; d <= 3; d++) cnt_q[d] <= '0;
			if (dig_q == '0) begin
				div_rem_q <= '0;
				div_quo_q <= DW'(sum_q);
				div_den_q <= DVW'(count_q);
			end
		end
		if (out_load) begin
			m_tdata_q <= {{(M_TDATA_W - 3 * SAMPLE_W){1'b0}}, max_q, ans_q,
				div_quo_q[SAMPLE_W-1:0]};
		end
	end

	`SWLS_ASSERT(a_rd_in_fill, clk, arst_n, issue_q |-> (CW'(rd_idx_q) < count_q), "read beyond filled entries")
	`SWLS_NEVER(a_busy_empty, clk, arst_n, (state_q != S_IDLE) && (count_q == '0), "busy with empty window")
	`SWLS_ASSERT(a_rank_range, clk, arst_n, (state_q == S_PASS) |-> (CW'(rank_q) < count_q), "rank outside window")
	`SWLS_ASSERT(a_pct_le_max, clk, arst_n, (state_q == S_MEAN_DIV) |-> (ans_q <= max_q), "percentile above max")

endmodule

`default_nettype wire

@@ rtl/swls_ram.sv @@
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module swls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench for sliding_window_latency_stats: streams duration samples, predicts mean,
// percentile and max for every request and compares each result field by field
// depends on swls_pkg and the rtl of the block
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import swls_pkg::*;

	localparam int HOLD_CYCLES   = 4000;
	localparam int CYCLE_LIMIT   = 5000000;
	localparam int PHASE_ITEMS   = 238;
	localparam int PHASES        = 6;
	localparam int DIRECTED_ROWS = 24;
	localparam int REPORT_CAP    = 100;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef enum int {RECV_SLOW, SEND_SLOW, NO_IDLE} idle_mode_t;
	typedef enum int {
		RUN_FULL, RUN_SMALL, RUN_EXTREME, RUN_NEAR_MAX, RUN_REPEAT, RUN_ONE_BIT, RUN_SATURATED
	} sample_run_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] max_us;
		logic [SAMPLE_W-1:0] percentile_us;
		logic [SAMPLE_W-1:0] mean_us;
	} latency_stats_t;

	typedef struct packed {
		logic                has_want;
		logic [SAMPLE_W-1:0] sample;
		latency_stats_t      want;
	} directed_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // sample_us
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // mean_us, percentile_us, max_us
	logic                 cfg_we = 1'b0;
	logic [PCT_W-1:0]     cfg_wdata = '0;

	logic [SAMPLE_W-1:0] window_q [WINDOW];
	int unsigned         write_slot;
	int unsigned         fill_count;
	logic [PCT_W-1:0]    pct_setting;
	latency_stats_t      stats_due [$];
	int unsigned         mismatches = 0;
	int unsigned         cycles = 0;
	int unsigned         send_idle_pct = 0;
	int unsigned         recv_idle_pct = 0;
	bit                  hold_pending = 1'b0;
	logic [SAMPLE_W-1:0] last_sample = '0;
	sample_run_t         run_kind = RUN_FULL;
	int                  run_left = 0;
	directed_row_t       directed_rows [DIRECTED_ROWS];

	sliding_window_latency_stats dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic latency_stats_t stats_after_sample(logic [SAMPLE_W-1:0] sample);
		logic [SAMPLE_W-1:0] sorted [WINDOW];
		logic [SAMPLE_W-1:0] v;
		logic [31:0]         total;
		int unsigned         pct;
		int unsigned         rank;
		int unsigned         i;
		int unsigned         j;
		latency_stats_t      r;
		window_q[write_slot] = sample;
		write_slot = (write_slot + 1) % WINDOW;
		if (fill_count < WINDOW) fill_count++;
		total = '0;
		r.max_us = '0;
		for (i = 0; i < fill_count; i++) begin
			v = window_q[i];
			total += v;
			if (v > r.max_us) r.max_us = v;
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		pct = (pct_setting > PCT_FULL) ? PCT_FULL : pct_setting;
		rank = (fill_count - 1) * pct / PCT_FULL;
		r.mean_us = SAMPLE_W'(total / fill_count);
		r.percentile_us = sorted[rank];
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] next_sample();
		logic [SAMPLE_W-1:0] s;
		int unsigned         pick;
		if (run_left == 0) begin
			pick = $urandom_range(19);
			run_kind = (pick == 0) ? RUN_SATURATED : sample_run_t'(pick % 6);
			run_left = (run_kind == RUN_SATURATED) ? $urandom_range(80, 10) : $urandom_range(12, 1);
		end
		run_left--;
		case (run_kind)
			RUN_FULL:     s = SAMPLE_W'($urandom);
			RUN_SMALL:    s = SAMPLE_W'($urandom_range(15));
			RUN_EXTREME:  s = $urandom_range(1) ? SAMPLE_MAX : '0;
			RUN_NEAR_MAX: s = SAMPLE_MAX - SAMPLE_W'($urandom_range(15));
			RUN_REPEAT:   s = last_sample;
			RUN_ONE_BIT:  s = SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
			default:      s = SAMPLE_MAX;
		endcase
		last_sample = s;
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < REPORT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			RECV_SLOW: begin
				send_idle_pct = 25;
				recv_idle_pct = 81;
			end
			SEND_SLOW: begin
				send_idle_pct = 81;
				recv_idle_pct = 25;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic has_want, latency_stats_t want);
		latency_stats_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(sample);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = stats_after_sample(sample);
		stats_due.push_back(has_want ? want : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (stats_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_percentile(logic [PCT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pct_setting = value;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		latency_stats_t got;
		latency_stats_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[3*SAMPLE_W-1:0];
			if (stats_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: 0x%015h", got));
			end else begin
				want = stats_due.pop_front();
				if (got.mean_us != want.mean_us)
					report_mismatch($sformatf("mean_us 0x%05h, want 0x%05h",
						got.mean_us, want.mean_us));
				if (got.percentile_us != want.percentile_us)
					report_mismatch($sformatf("percentile_us 0x%05h, want 0x%05h",
						got.percentile_us, want.percentile_us));
				if (got.max_us != want.max_us)
					report_mismatch($sformatf("max_us 0x%05h, want 0x%05h",
						got.max_us, want.max_us));
			end
		end
	end

	// receiver side, with one long hold-off so the block backs up
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [PCT_W-1:0] pct_plan [PHASES];
		int unsigned      phase;
		int unsigned      n;
		for (n = 0; n < WINDOW; n++) window_q[n] = '0;
		write_slot = 0;
		fill_count = 0;
		pct_setting = PCT_RESET;
		pct_plan = '{7'd0, 7'd100, 7'd127, 7'd101, 7'd50, 7'd1};
		// first two rows follow from a single value in the window
		directed_rows = '{
			'{1'b1, 20'hFFFFF, '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF}},
			'{1'b1, 20'hFFFFF, '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF}},
			'{1'b0, 20'h00000, '0},
			'{1'b0, 20'h00000, '0},
			'{1'b0, 20'h00001, '0},
			'{1'b0, 20'h80000, '0},
			'{1'b0, 20'h7FFFF, '0},
			'{1'b0, 20'h00005, '0},
			'{1'b0, 20'h00005, '0},
			'{1'b0, 20'h00005, '0},
			'{1'b0, 20'hAAAAA, '0},
			'{1'b0, 20'h55555, '0},
			'{1'b0, 20'hFFFFE, '0},
			'{1'b0, 20'h00002, '0},
			'{1'b0, 20'h00003, '0},
			'{1'b0, 20'h12345, '0},
			'{1'b0, 20'hFEDCB, '0},
			'{1'b0, 20'h00010, '0},
			'{1'b0, 20'h40000, '0},
			'{1'b0, 20'h20000, '0},
			'{1'b0, 20'h00003, '0},
			'{1'b0, 20'h00003, '0},
			'{1'b0, 20'hFFFFF, '0},
			'{1'b0, 20'h00001, '0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(RECV_SLOW);
		for (n = 0; n < DIRECTED_ROWS; n++)
			send_sample(directed_rows[n].sample, directed_rows[n].has_want, directed_rows[n].want);
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			if (phase == PHASES - 1)
				write_percentile(PCT_W'($urandom_range(127)));
			else
				write_percentile(pct_plan[phase]);
			set_idle(idle_mode_t'((phase + 1) % 3));
			if (phase == 1) hold_pending = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) send_sample(next_sample(), 1'b0, '0);
		end
		drain_results();
		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
